>>> rtl/bcpe_pkg.sv
package bcpe_pkg;

  localparam int POINT_CAPACITY = 16;
  localparam int DEGREE_LIMIT   = 3;
  localparam int FRAC_BITS      = 16;
  localparam int KNOT_DEPTH     = POINT_CAPACITY + DEGREE_LIMIT + 1;
  localparam int WEIGHT_DEPTH   = KNOT_DEPTH - 1;

  localparam int KNOT_W   = FRAC_BITS + 1;
  localparam int WEIGHT_W = FRAC_BITS + 1;
  localparam int COORD_W  = 32;
  localparam int NUM_W    = KNOT_W + WEIGHT_W;
  localparam int SUM_W    = NUM_W + 2;
  localparam int PROD_W   = COORD_W + 1 + WEIGHT_W + 1;
  localparam int ACC_W    = PROD_W + $clog2(POINT_CAPACITY);
  localparam int IDX_W    = $clog2(KNOT_DEPTH);
  localparam int WIDX_W   = $clog2(WEIGHT_DEPTH);
  localparam int CP_W     = $clog2(POINT_CAPACITY);
  localparam int DEG_W    = 2;
  localparam int LAST_W   = 4;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_BITS;

  localparam logic [0:0] REG_DEGREE     = 1'b0;
  localparam logic [0:0] REG_LAST_POINT = 1'b1;

  typedef enum logic [1:0] {
    OP_KNOT  = 2'd0,
    OP_POINT = 2'd1,
    OP_EVAL  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [4:0]         slot;
    logic [16:0]        knot_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [16:0]        param_t;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] curve_x;
    logic signed [31:0] curve_y;
    logic signed [31:0] curve_z;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  dividend;
    logic [KNOT_W-1:0] divisor;
  } div_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_L0_LO,
    S_L0_HI,
    S_RD_LO,
    S_RD_K1,
    S_RD_KD,
    S_RD_HI,
    S_CHECK,
    S_T1,
    S_D1S,
    S_D1W,
    S_T2,
    S_D2S,
    S_D2W,
    S_WR,
    S_A_W,
    S_A_X,
    S_A_Y,
    S_A_Z,
    S_A_E,
    S_FIN
  } state_t;

  // round half up to the integer grid, then clamp to signed 32 bits
  function automatic logic signed [COORD_W-1:0] finish(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] v;
    logic signed [ACC_W-1:0] q;
    v = acc + (ACC_W'(1) <<< (FRAC_BITS - 1));
    q = v >>> FRAC_BITS;
    if (q > ACC_W'(64'sh7FFFFFFF)) begin
      finish = 32'sh7FFFFFFF;
    end else if (q < -(ACC_W'(64'sh80000000))) begin
      finish = 32'sh80000000;
    end else begin
      finish = q[COORD_W-1:0];
    end
  endfunction

endpackage

>>> rtl/bcpe_div.sv
module bcpe_div (
  input  logic                       clk,
  input  logic                       rst,
  input  bcpe_pkg::div_req_t         req,
  output logic                       done,
  output logic [bcpe_pkg::NUM_W-1:0] quotient
);

  localparam int NW = bcpe_pkg::NUM_W;
  localparam int DW = bcpe_pkg::KNOT_W;
  localparam int CW = $clog2(NW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW:0]   rem;
  logic [NW-1:0] work;
  logic [DW:0]   rem_sh;
  logic          fits;

  // restoring division, one quotient bit a cycle
  assign rem_sh   = {rem[DW-1:0], work[NW-1]};
  assign fits     = rem_sh >= {1'b0, req.divisor};
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      work <= req.dividend;
    end else if (busy) begin
      rem  <= fits ? rem_sh - {1'b0, req.divisor} : rem_sh;
      work <= {work[NW-2:0], fits};
    end
  end

endmodule

>>> rtl/bspline_curve_point_evaluator_core.sv
// B-spline curve point evaluator, Cox-de Boor recursion in fixed point. Load beats
// (opcode knot or point) are absorbed in the accept cycle; an evaluate beat starts a
// sequencer that rebuilds the basis triangle in place, level by level, then sweeps the
// control points and returns one result beat. Knots and t are unsigned Q1.16, weights
// are Q1.16 clamped to 0..1.0, coordinates are signed Q32.0 integers with round half up and
// saturation. With k the degree and n = last_point_index, level zero reads the low and
// high knot of each of its n + k + 1 entries; each higher level d has n + k + 1 - d
// entries, each read and checked against its span and, if t lies inside it, built
// from up to two division terms (a zero weight or a zero knot difference skips a
// term). The control point sweep then skips points with zero weight and multiplies
// the others, then a finish step rounds and saturates. The 34-step serial divider
// dominates; in_ready is low for the whole evaluation.
// A finished result sits in the output register while new beats are taken.
module bspline_curve_point_evaluator_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bcpe_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bcpe_pkg::out_item_t              out_data,
  input  logic                             cfg_write,
  input  logic [0:0]                       cfg_index,
  input  logic [bcpe_pkg::LAST_W-1:0]      cfg_data
);

  localparam int KW  = bcpe_pkg::KNOT_W;
  localparam int WW  = bcpe_pkg::WEIGHT_W;
  localparam int IW  = bcpe_pkg::IDX_W;
  localparam int XW  = bcpe_pkg::WIDX_W;
  localparam int SW  = bcpe_pkg::SUM_W;
  localparam int PW  = bcpe_pkg::PROD_W;
  localparam int AW  = bcpe_pkg::ACC_W;
  localparam int CPW = bcpe_pkg::CP_W;
  localparam int DGW = bcpe_pkg::DEG_W;
  localparam int LW  = bcpe_pkg::LAST_W;

  // tables, undefined until loaded
  logic [KW-1:0]        knot_table [bcpe_pkg::KNOT_DEPTH];
  logic signed [31:0]   ctrl_x_table [bcpe_pkg::POINT_CAPACITY];
  logic signed [31:0]   ctrl_y_table [bcpe_pkg::POINT_CAPACITY];
  logic signed [31:0]   ctrl_z_table [bcpe_pkg::POINT_CAPACITY];
  // basis triangle, overwritten in place one level at a time
  logic [WW-1:0]        w_tab [bcpe_pkg::WEIGHT_DEPTH];

  logic [DGW-1:0] degree;
  logic [LW-1:0]  last_point_index;

  bcpe_pkg::state_t state, state_next;

  logic [IW-1:0]  idx;
  logic [DGW-1:0] lvl;
  logic [DGW-1:0] k_r;
  logic [LW-1:0]  last_r;
  logic [IW-1:0]  top;
  logic [KW-1:0]  t_r;
  logic [KW-1:0]  kn_lo, kn_k1, kn_kd, kn_hi;
  logic [WW-1:0]  wa, wb;
  logic signed [SW-1:0] sum;
  logic [KW-1:0]  den_mag;
  logic           den_neg;
  logic signed [PW-1:0] mul_p;
  logic signed [AW-1:0] acc_x, acc_y, acc_z;

  logic               in_fire;
  logic [IW-1:0]      knot_addr;
  logic [KW-1:0]      knot_rd;
  logic [IW-1:0]      w_addr;
  logic [WW-1:0]      w_rd;
  logic               entry_end;
  logic               out_of_span;
  logic signed [KW:0] den1, den2;
  logic signed [32:0] mul_a;
  logic signed [WW:0] mul_b;
  logic signed [PW-1:0] prod;
  logic [WW-1:0]      sum_sat;
  logic               out_free;
  logic [DGW-1:0]     k_eff;
  logic [LW-1:0]      last_eff;
  logic [KW-1:0]      t_minus_lo, hi_minus_t;

  bcpe_pkg::div_req_t        div_req;
  logic                      div_done;
  logic [bcpe_pkg::NUM_W-1:0] div_q;

  bcpe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_ready = (state == bcpe_pkg::S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // clamp the registers to what the tables hold
  assign k_eff    = (32'(degree) > bcpe_pkg::DEGREE_LIMIT) ?
                    DGW'(bcpe_pkg::DEGREE_LIMIT) : degree;
  assign last_eff = (32'(last_point_index) >= bcpe_pkg::POINT_CAPACITY) ?
                    LW'(bcpe_pkg::POINT_CAPACITY - 1) : last_point_index;

  // one knot read and one weight read a cycle, address set by the step
  always_comb begin
    unique case (state)
      bcpe_pkg::S_L0_HI, bcpe_pkg::S_RD_K1: knot_addr = idx + 1'b1;
      bcpe_pkg::S_RD_KD:                    knot_addr = idx + IW'(lvl);
      bcpe_pkg::S_RD_HI:                    knot_addr = idx + IW'(lvl) + 1'b1;
      default:                              knot_addr = idx;
    endcase
  end
  assign knot_rd = knot_table[knot_addr];
  assign w_addr  = (state == bcpe_pkg::S_RD_K1) ? idx + 1'b1 : idx;
  assign w_rd    = w_tab[w_addr[XW-1:0]];

  assign entry_end   = (idx == top - IW'(lvl));
  assign out_of_span = (t_r < kn_lo) || (t_r >= kn_hi);
  assign den1        = $signed({1'b0, kn_kd}) - $signed({1'b0, kn_lo});
  assign den2        = $signed({1'b0, kn_hi}) - $signed({1'b0, kn_k1});
  assign t_minus_lo  = t_r - kn_lo;
  assign hi_minus_t  = kn_hi - t_r;

  // shared multiplier: basis numerators and coordinate times weight
  always_comb begin
    unique case (state)
      bcpe_pkg::S_T1: begin
        mul_a = $signed({16'd0, t_minus_lo});
        mul_b = $signed({1'b0, wa});
      end
      bcpe_pkg::S_T2: begin
        mul_a = $signed({16'd0, hi_minus_t});
        mul_b = $signed({1'b0, wb});
      end
      bcpe_pkg::S_A_X: begin
        mul_a = 33'(ctrl_x_table[idx[CPW-1:0]]);
        mul_b = $signed({1'b0, wa});
      end
      bcpe_pkg::S_A_Y: begin
        mul_a = 33'(ctrl_y_table[idx[CPW-1:0]]);
        mul_b = $signed({1'b0, wa});
      end
      bcpe_pkg::S_A_Z: begin
        mul_a = 33'(ctrl_z_table[idx[CPW-1:0]]);
        mul_b = $signed({1'b0, wa});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = PW'(mul_a) * PW'(mul_b);

  // weight clamp into 0 .. 1.0
  always_comb begin
    if (sum < 0) begin
      sum_sat = '0;
    end else if (sum > $signed(SW'(bcpe_pkg::WEIGHT_ONE))) begin
      sum_sat = bcpe_pkg::WEIGHT_ONE;
    end else begin
      sum_sat = sum[WW-1:0];
    end
  end

  assign div_req.start    = (state == bcpe_pkg::S_D1S) || (state == bcpe_pkg::S_D2S);
  assign div_req.dividend = mul_p[bcpe_pkg::NUM_W-1:0];
  assign div_req.divisor  = den_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bcpe_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bcpe_pkg::S_IDLE: begin
        if (in_fire && in_data.opcode == bcpe_pkg::OP_EVAL) begin
          state_next = bcpe_pkg::S_L0_LO;
        end
      end
      bcpe_pkg::S_L0_LO: state_next = bcpe_pkg::S_L0_HI;
      bcpe_pkg::S_L0_HI: begin
        if (!entry_end) begin
          state_next = bcpe_pkg::S_L0_LO;
        end else if (lvl == k_r) begin
          state_next = bcpe_pkg::S_A_W;
        end else begin
          state_next = bcpe_pkg::S_RD_LO;
        end
      end
      bcpe_pkg::S_RD_LO: state_next = bcpe_pkg::S_RD_K1;
      bcpe_pkg::S_RD_K1: state_next = bcpe_pkg::S_RD_KD;
      bcpe_pkg::S_RD_KD: state_next = bcpe_pkg::S_RD_HI;
      bcpe_pkg::S_RD_HI: state_next = bcpe_pkg::S_CHECK;
      bcpe_pkg::S_CHECK: begin
        if (!out_of_span) begin
          state_next = bcpe_pkg::S_T1;
        end else if (entry_end && lvl == k_r) begin
          state_next = bcpe_pkg::S_A_W;
        end else begin
          state_next = bcpe_pkg::S_RD_LO;
        end
      end
      bcpe_pkg::S_T1: begin
        state_next = (den1 != 0 && wa != '0) ? bcpe_pkg::S_D1S : bcpe_pkg::S_T2;
      end
      bcpe_pkg::S_D1S: state_next = bcpe_pkg::S_D1W;
      bcpe_pkg::S_D1W: begin
        if (div_done) begin
          state_next = bcpe_pkg::S_T2;
        end
      end
      bcpe_pkg::S_T2: begin
        state_next = (den2 != 0 && wb != '0) ? bcpe_pkg::S_D2S : bcpe_pkg::S_WR;
      end
      bcpe_pkg::S_D2S: state_next = bcpe_pkg::S_D2W;
      bcpe_pkg::S_D2W: begin
        if (div_done) begin
          state_next = bcpe_pkg::S_WR;
        end
      end
      bcpe_pkg::S_WR: begin
        state_next = (entry_end && lvl == k_r) ? bcpe_pkg::S_A_W : bcpe_pkg::S_RD_LO;
      end
      bcpe_pkg::S_A_W: state_next = bcpe_pkg::S_A_X;
      bcpe_pkg::S_A_X: begin
        if (wa != '0) begin
          state_next = bcpe_pkg::S_A_Y;
        end else if (idx == IW'(last_r)) begin
          state_next = bcpe_pkg::S_FIN;
        end else begin
          state_next = bcpe_pkg::S_A_W;
        end
      end
      bcpe_pkg::S_A_Y: state_next = bcpe_pkg::S_A_Z;
      bcpe_pkg::S_A_Z: state_next = bcpe_pkg::S_A_E;
      bcpe_pkg::S_A_E: begin
        state_next = (idx == IW'(last_r)) ? bcpe_pkg::S_FIN : bcpe_pkg::S_A_W;
      end
      bcpe_pkg::S_FIN: begin
        if (out_free) begin
          state_next = bcpe_pkg::S_IDLE;
        end
      end
      default: state_next = bcpe_pkg::S_IDLE;
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      degree           <= DGW'(3);
      last_point_index <= LW'(8);
    end else if (cfg_write) begin
      unique case (cfg_index)
        bcpe_pkg::REG_DEGREE:     degree           <= cfg_data[DGW-1:0];
        bcpe_pkg::REG_LAST_POINT: last_point_index <= cfg_data;
        default: ;
      endcase
    end
  end

  // table loads
  always_ff @(posedge clk) begin
    if (in_fire && in_data.opcode == bcpe_pkg::OP_KNOT &&
        32'(in_data.slot) < bcpe_pkg::KNOT_DEPTH) begin
      knot_table[in_data.slot[IW-1:0]] <= in_data.knot_value;
    end
    if (in_fire && in_data.opcode == bcpe_pkg::OP_POINT &&
        32'(in_data.slot) < bcpe_pkg::POINT_CAPACITY) begin
      ctrl_x_table[in_data.slot[CPW-1:0]] <= in_data.point_x;
      ctrl_y_table[in_data.slot[CPW-1:0]] <= in_data.point_y;
      ctrl_z_table[in_data.slot[CPW-1:0]] <= in_data.point_z;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == bcpe_pkg::S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bcpe_pkg::S_FIN && out_free) begin
      out_data.curve_x <= bcpe_pkg::finish(acc_x);
      out_data.curve_y <= bcpe_pkg::finish(acc_y);
      out_data.curve_z <= bcpe_pkg::finish(acc_z);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      bcpe_pkg::S_IDLE: begin
        if (in_fire && in_data.opcode == bcpe_pkg::OP_EVAL) begin
          t_r    <= in_data.param_t;
          k_r    <= k_eff;
          last_r <= last_eff;
          top    <= IW'(last_eff) + IW'(k_eff);
          idx    <= '0;
          lvl    <= '0;
          acc_x  <= '0;
          acc_y  <= '0;
          acc_z  <= '0;
        end
      end
      bcpe_pkg::S_L0_LO: kn_lo <= knot_rd;
      bcpe_pkg::S_L0_HI: begin
        // level zero: half-open interval test
        w_tab[idx[XW-1:0]] <= (t_r >= kn_lo && t_r < knot_rd) ? bcpe_pkg::WEIGHT_ONE : '0;
        if (entry_end) begin
          idx <= '0;
          if (lvl != k_r) begin
            lvl <= lvl + 1'b1;
          end
        end else begin
          idx <= idx + 1'b1;
        end
      end
      bcpe_pkg::S_RD_LO: begin
        kn_lo <= knot_rd;
        wa    <= w_rd;
      end
      bcpe_pkg::S_RD_K1: begin
        kn_k1 <= knot_rd;
        wb    <= w_rd;
      end
      bcpe_pkg::S_RD_KD: kn_kd <= knot_rd;
      bcpe_pkg::S_RD_HI: kn_hi <= knot_rd;
      bcpe_pkg::S_CHECK: begin
        sum <= '0;
        if (out_of_span) begin
          w_tab[idx[XW-1:0]] <= '0;
          if (entry_end) begin
            idx <= '0;
            if (lvl != k_r) begin
              lvl <= lvl + 1'b1;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
      end
      bcpe_pkg::S_T1: begin
        mul_p   <= prod;
        den_neg <= den1 < 0;
        den_mag <= (den1 < 0) ? KW'(-den1) : KW'(den1);
      end
      bcpe_pkg::S_D1W, bcpe_pkg::S_D2W: begin
        if (div_done) begin
          // negative knot difference flips the sign of the term
          sum <= den_neg ? sum - $signed(SW'(div_q)) : sum + $signed(SW'(div_q));
        end
      end
      bcpe_pkg::S_T2: begin
        mul_p   <= prod;
        den_neg <= den2 < 0;
        den_mag <= (den2 < 0) ? KW'(-den2) : KW'(den2);
      end
      bcpe_pkg::S_WR: begin
        w_tab[idx[XW-1:0]] <= sum_sat;
        if (entry_end) begin
          idx <= '0;
          if (lvl != k_r) begin
            lvl <= lvl + 1'b1;
          end
        end else begin
          idx <= idx + 1'b1;
        end
      end
      bcpe_pkg::S_A_W: wa <= w_rd;
      bcpe_pkg::S_A_X: begin
        mul_p <= prod;
        if (wa == '0 && idx != IW'(last_r)) begin
          idx <= idx + 1'b1;
        end
      end
      bcpe_pkg::S_A_Y: begin
        acc_x <= acc_x + AW'(mul_p);
        mul_p <= prod;
      end
      bcpe_pkg::S_A_Z: begin
        acc_y <= acc_y + AW'(mul_p);
        mul_p <= prod;
      end
      bcpe_pkg::S_A_E: begin
        acc_z <= acc_z + AW'(mul_p);
        if (idx != IW'(last_r)) begin
          idx <= idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
